// File: sv/hcbm_pkg.sv
package hcbm_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 11;
    localparam int HITS_W  = 23;
    localparam int SUM_W   = 33;
    localparam int NUM_REGS = 7;
    localparam int IDX_W   = 3;

    localparam logic [IDX_W-1:0] REG_T0_HUE = 3'd0;
    localparam logic [IDX_W-1:0] REG_T0_SAT = 3'd1;
    localparam logic [IDX_W-1:0] REG_T0_VAL = 3'd2;
    localparam logic [IDX_W-1:0] REG_T1_HUE = 3'd3;
    localparam logic [IDX_W-1:0] REG_T1_SAT = 3'd4;
    localparam logic [IDX_W-1:0] REG_T1_VAL = 3'd5;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd6;

    localparam logic [PIX_W-1:0] TOL_RESET = 8'd10;
    localparam logic [HITS_W-1:0] COUNT_MAX = {HITS_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture a new pixel
        logic div_start; // begin both divisions
        logic div_step;  // one quotient bit
        logic accum;     // test and accumulate
        logic emit;      // frame end: latch result and clear
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic div_done;
        logic frame_end;
    } ctrl_sts_t;

endpackage

// File: sv/hsv_color_blob_moments.sv
// A pixel is captured on acceptance, divided, then accumulated; a frame result is
// valid the cycle after its frame-end pixel accumulates.
// A new pixel is accepted only after the previous one has accumulated, paced
// by the bit-serial saturation and hue dividers (one quotient bit per cycle
// over 18 steps); a frame end also waits while the previous result is pending.
// Reset (aresetn low, synchronous): clears targets, tolerance to 10, all
// accumulators and the result valid flag.
module hsv_color_blob_moments #(
    parameter int NUM_COLORS = 2,
    parameter int MAX_SIDE   = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [hcbm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hcbm_pkg::PIX_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_red,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_green,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_blue,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_x,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_y,
    input  logic                         s_frame_end,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found0,
    output logic [hcbm_pkg::HITS_W-1:0]  m_hits0,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumx0,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumy0,
    output logic                         m_found1,
    output logic [hcbm_pkg::HITS_W-1:0]  m_hits1,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumx1,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumy1
);
    import hcbm_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    assign cfg_ready = 1'b1;

    hcbm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    hcbm_datapath #(
        .NUM_COLORS (NUM_COLORS),
        .MAX_SIDE   (MAX_SIDE)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_red       (s_red),
        .s_green     (s_green),
        .s_blue      (s_blue),
        .s_pos_x     (s_pos_x),
        .s_pos_y     (s_pos_y),
        .s_frame_end (s_frame_end),
        .m_found0    (m_found0),
        .m_hits0     (m_hits0),
        .m_sumx0     (m_sumx0),
        .m_sumy0     (m_sumy0),
        .m_found1    (m_found1),
        .m_hits1     (m_hits1),
        .m_sumx1     (m_sumx1),
        .m_sumy1     (m_sumy1)
    );

`ifndef SYNTH
    // A result transaction is only produced by an emit, and never over one pending.
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_valid || m_ready))
        else $error("emit while result pending");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> m_valid)
        else $error("emit did not raise m_valid");
    a_found_hits: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_found0 == (m_hits0 != '0)) && (m_found1 == (m_hits1 != '0)))
        else $error("found flag disagrees with hit count");
`endif

endmodule

// File: sv/hcbm_ctrl.sv
module hcbm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output hcbm_pkg::ctrl_cmd_t cmd,
    input  hcbm_pkg::ctrl_sts_t sts
);
    import hcbm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_ACC  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       mvalid_reg, mvalid_next;

    // A finished frame result waits in the output register; the next pixel
    // may still enter, but accumulation of a frame end waits for it to drain.
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = mvalid_reg;

    always_comb begin
        state_next  = state_reg;
        mvalid_next = mvalid_reg;
        cmd         = '0;
        if (mvalid_reg && m_ready) begin
            mvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                if (!sts.frame_end) begin
                    cmd.accum  = 1'b1;
                    state_next = ST_IDLE;
                end else if (!mvalid_next) begin
                    cmd.accum   = 1'b1;
                    cmd.emit    = 1'b1;
                    mvalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

// File: sv/hcbm_datapath.sv
module hcbm_datapath #(
    parameter int NUM_COLORS = 2,
    parameter int MAX_SIDE   = 2048
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  hcbm_pkg::ctrl_cmd_t          cmd,
    output hcbm_pkg::ctrl_sts_t          sts,
    input  logic                         cfg_valid,
    input  logic [hcbm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hcbm_pkg::PIX_W-1:0]   cfg_data,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_red,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_green,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_blue,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_x,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_y,
    input  logic                         s_frame_end,
    output logic                         m_found0,
    output logic [hcbm_pkg::HITS_W-1:0]  m_hits0,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumx0,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumy0,
    output logic                         m_found1,
    output logic [hcbm_pkg::HITS_W-1:0]  m_hits1,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumx1,
    output logic [hcbm_pkg::SUM_W-1:0]   m_sumy1
);
    import hcbm_pkg::*;

    localparam int SLOTS = 2;
    localparam logic [COORD_W-1:0] SIDE_MAX = COORD_W'(MAX_SIDE - 1);
    // Dividends: 510*diff + mx < 2^17; 2*num + diff < 2^18 (num < 180*diff).
    localparam int NUM_W  = 18;
    localparam int DEN_W  = 9;
    localparam int QBITS  = 9;
    localparam int CNT_W  = 5;

    // Configuration registers.
    logic [PIX_W-1:0] tgt_reg [SLOTS][3];
    logic [PIX_W-1:0] tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                for (int c = 0; c < 3; c++) begin
                    tgt_reg[k][c] <= '0;
                end
            end
            tol_reg <= TOL_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_T0_HUE: tgt_reg[0][0] <= cfg_data;
                REG_T0_SAT: tgt_reg[0][1] <= cfg_data;
                REG_T0_VAL: tgt_reg[0][2] <= cfg_data;
                REG_T1_HUE: tgt_reg[1][0] <= cfg_data;
                REG_T1_SAT: tgt_reg[1][1] <= cfg_data;
                REG_T1_VAL: tgt_reg[1][2] <= cfg_data;
                REG_TOL:    tol_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    // Captured pixel.
    logic [COORD_W-1:0] px_reg, py_reg;
    logic               fe_reg;
    logic [PIX_W-1:0]   val_reg;
    logic               grey_reg;

    // Max/min and hue numerator of the incoming pixel.
    logic [PIX_W-1:0] mx, mn, diff;
    logic [NUM_W-1:0] hnum;
    logic signed [17:0] num_s;

    always_comb begin
        mx = s_red;
        if (s_green > mx) mx = s_green;
        if (s_blue > mx) mx = s_blue;
        mn = s_red;
        if (s_green < mn) mn = s_green;
        if (s_blue < mn) mn = s_blue;
        diff = mx - mn;
        if (mx == s_red) begin
            num_s = 18'sd30 * ($signed({10'd0, s_green}) - $signed({10'd0, s_blue}));
        end else if (mx == s_green) begin
            num_s = 18'sd60 * $signed({10'd0, diff})
                  + 18'sd30 * ($signed({10'd0, s_blue}) - $signed({10'd0, s_red}));
        end else begin
            num_s = 18'sd120 * $signed({10'd0, diff})
                  + 18'sd30 * ($signed({10'd0, s_red}) - $signed({10'd0, s_green}));
        end
        if (num_s < 0) begin
            num_s = num_s + 18'sd180 * $signed({10'd0, diff});
        end
        hnum = NUM_W'(2 * num_s + $signed({10'd0, diff}));
    end

    // Two restoring dividers, one quotient bit a cycle.
    logic [NUM_W-1:0] sn_reg, hn_reg;
    logic [DEN_W-1:0] sd_reg, hd_reg;
    logic [NUM_W-1:0] srem_reg, hrem_reg;
    logic [QBITS-1:0] sq_reg, hq_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] srem_sh, hrem_sh;

    assign srem_sh = {srem_reg[NUM_W-2:0], sn_reg[NUM_W-1]};
    assign hrem_sh = {hrem_reg[NUM_W-2:0], hn_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg   <= (s_pos_x > SIDE_MAX) ? SIDE_MAX : s_pos_x;
            py_reg   <= (s_pos_y > SIDE_MAX) ? SIDE_MAX : s_pos_y;
            fe_reg   <= s_frame_end;
            val_reg  <= mx;
            grey_reg <= (diff == '0);
        end
        if (cmd.div_start) begin
            sn_reg   <= NUM_W'(17'd510 * diff + mx);
            sd_reg   <= {mx, 1'b0};
            hn_reg   <= hnum;
            hd_reg   <= {diff, 1'b0};
            srem_reg <= '0;
            hrem_reg <= '0;
            sq_reg   <= '0;
            hq_reg   <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            sn_reg  <= {sn_reg[NUM_W-2:0], 1'b0};
            hn_reg  <= {hn_reg[NUM_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
            if (srem_sh >= NUM_W'(sd_reg)) begin
                srem_reg <= srem_sh - NUM_W'(sd_reg);
                sq_reg   <= {sq_reg[QBITS-2:0], 1'b1};
            end else begin
                srem_reg <= srem_sh;
                sq_reg   <= {sq_reg[QBITS-2:0], 1'b0};
            end
            if (hrem_sh >= NUM_W'(hd_reg)) begin
                hrem_reg <= hrem_sh - NUM_W'(hd_reg);
                hq_reg   <= {hq_reg[QBITS-2:0], 1'b1};
            end else begin
                hrem_reg <= hrem_sh;
                hq_reg   <= {hq_reg[QBITS-2:0], 1'b0};
            end
        end
    end

    assign sts.div_done  = (cnt_reg == CNT_W'(NUM_W - 1));
    assign sts.frame_end = fe_reg;

    // Final HSV.
    logic [PIX_W-1:0] hsv [3];
    always_comb begin
        if (grey_reg) begin
            hsv[0] = '0;
        end else if (hq_reg >= QBITS'(180)) begin
            hsv[0] = PIX_W'(hq_reg - QBITS'(180));
        end else begin
            hsv[0] = hq_reg[PIX_W-1:0];
        end
        hsv[1] = (val_reg == '0) ? '0 : sq_reg[PIX_W-1:0];
        hsv[2] = val_reg;
    end

    // Accumulators.
    logic [HITS_W-1:0] cnt_acc_reg [SLOTS];
    logic [SUM_W-1:0]  xs_reg [SLOTS];
    logic [SUM_W-1:0]  ys_reg [SLOTS];
    logic [SLOTS-1:0]  en, hit;
    logic [SUM_W:0]    xs_add [SLOTS];
    logic [SUM_W:0]    ys_add [SLOTS];

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            en[k]  = (k < NUM_COLORS) && (tgt_reg[k][0] != '0) &&
                     (tgt_reg[k][1] != '0) && (tgt_reg[k][2] != '0);
            hit[k] = en[k];
            for (int c = 0; c < 3; c++) begin
                if ({1'b0, hsv[c]} + {1'b0, tol_reg} < {1'b0, tgt_reg[k][c]} ||
                    {1'b0, hsv[c]} > {1'b0, tgt_reg[k][c]} + {1'b0, tol_reg}) begin
                    hit[k] = 1'b0;
                end
            end
            xs_add[k] = {1'b0, xs_reg[k]} + (SUM_W+1)'(px_reg);
            ys_add[k] = {1'b0, ys_reg[k]} + (SUM_W+1)'(py_reg);
        end
    end

    logic [HITS_W-1:0] cnt_new [SLOTS];
    logic [SUM_W-1:0]  xs_new [SLOTS];
    logic [SUM_W-1:0]  ys_new [SLOTS];

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            cnt_new[k] = cnt_acc_reg[k];
            xs_new[k]  = xs_reg[k];
            ys_new[k]  = ys_reg[k];
            if (hit[k]) begin
                if (cnt_acc_reg[k] != COUNT_MAX) cnt_new[k] = cnt_acc_reg[k] + 1'b1;
                xs_new[k] = xs_add[k][SUM_W] ? SUM_MAX : xs_add[k][SUM_W-1:0];
                ys_new[k] = ys_add[k][SUM_W] ? SUM_MAX : ys_add[k][SUM_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SLOTS; k++) begin
                cnt_acc_reg[k] <= '0;
                xs_reg[k]      <= '0;
                ys_reg[k]      <= '0;
            end
        end else if (cmd.accum) begin
            for (int k = 0; k < SLOTS; k++) begin
                cnt_acc_reg[k] <= cmd.emit ? '0 : cnt_new[k];
                xs_reg[k]      <= cmd.emit ? '0 : xs_new[k];
                ys_reg[k]      <= cmd.emit ? '0 : ys_new[k];
            end
        end
    end

    // Result register.
    logic [SLOTS-1:0]  found_reg;
    logic [HITS_W-1:0] ohits_reg [SLOTS];
    logic [SUM_W-1:0]  osx_reg [SLOTS];
    logic [SUM_W-1:0]  osy_reg [SLOTS];
    logic [SLOTS-1:0]  fnd;

    always_comb begin
        for (int k = 0; k < SLOTS; k++) begin
            fnd[k] = en[k] && (cnt_new[k] != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            for (int k = 0; k < SLOTS; k++) begin
                found_reg[k] <= fnd[k];
                ohits_reg[k] <= fnd[k] ? cnt_new[k] : '0;
                osx_reg[k]   <= fnd[k] ? xs_new[k] : '0;
                osy_reg[k]   <= fnd[k] ? ys_new[k] : '0;
            end
        end
    end

    assign m_found0 = found_reg[0];
    assign m_hits0  = ohits_reg[0];
    assign m_sumx0  = osx_reg[0];
    assign m_sumy0  = osy_reg[0];
    assign m_found1 = found_reg[1];
    assign m_hits1  = ohits_reg[1];
    assign m_sumx1  = osx_reg[1];
    assign m_sumy1  = osy_reg[1];

endmodule

// File: tb/sv/hsv_color_blob_moments_checker.sv
`timescale 1ns / 100ps

module hsv_color_blob_moments_checker (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic                         cfg_ready,
    input  logic [hcbm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [hcbm_pkg::PIX_W-1:0]   cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_red,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_green,
    input  logic [hcbm_pkg::PIX_W-1:0]   s_blue,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_x,
    input  logic [hcbm_pkg::COORD_W-1:0] s_pos_y,
    input  logic                         s_frame_end,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_found0,
    input  logic [hcbm_pkg::HITS_W-1:0]  m_hits0,
    input  logic [hcbm_pkg::SUM_W-1:0]   m_sumx0,
    input  logic [hcbm_pkg::SUM_W-1:0]   m_sumy0,
    input  logic                         m_found1,
    input  logic [hcbm_pkg::HITS_W-1:0]  m_hits1,
    input  logic [hcbm_pkg::SUM_W-1:0]   m_sumx1,
    input  logic [hcbm_pkg::SUM_W-1:0]   m_sumy1,
    output int                           fail_count,
    output int                           frames_pending
);
    import hcbm_pkg::*;

    typedef struct packed {
        logic              found;
        logic [HITS_W-1:0] hits;
        logic [SUM_W-1:0]  sumx;
        logic [SUM_W-1:0]  sumy;
    } blob_t;

    typedef struct packed {
        blob_t b0;
        blob_t b1;
    } frame_moments_t;

    frame_moments_t moments_q[$];

    logic [7:0]  target[2][3];
    logic [7:0]  tol;
    logic [22:0] hit_cnt[2];
    longint      x_acc[2];
    longint      y_acc[2];

    // Returns {hue, sat, val}, hue as degrees/2 rounded.
    function automatic logic [23:0] rgb_to_hsv(input int r, input int g, input int b);
        int mx, mn, diff, num, h, s;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        diff = mx - mn;
        s = (mx == 0) ? 0 : (510 * diff + mx) / (2 * mx);
        h = 0;
        if (diff != 0) begin
            if (mx == r) num = 30 * (g - b);
            else if (mx == g) num = 60 * diff + 30 * (b - r);
            else num = 120 * diff + 30 * (r - g);
            if (num < 0) num += 180 * diff;
            h = (2 * num + diff) / (2 * diff);
            if (h >= 180) h -= 180;
        end
        return {h[7:0], s[7:0], mx[7:0]};
    endfunction

    function automatic bit slot_on(input int k);
        return target[k][0] != 0 && target[k][1] != 0 && target[k][2] != 0;
    endfunction

    function automatic blob_t close_slot(input int k);
        blob_t b;
        b = '0;
        if (slot_on(k) && hit_cnt[k] != 0) begin
            b.found = 1'b1;
            b.hits = hit_cnt[k];
            b.sumx = x_acc[k][SUM_W-1:0];
            b.sumy = y_acc[k][SUM_W-1:0];
        end
        return b;
    endfunction

    task automatic report(input string what, input logic [63:0] exp_v, input logic [63:0] got);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch %s: expected %0d, actual %0d", what, exp_v, got);
    endtask

    always @(posedge aclk) begin
        logic [23:0] hsv;
        int c, lo, hi;
        bit hit;
        frame_moments_t e, a;
        if (!aresetn) begin
            for (int k = 0; k < 2; k++) begin
                for (c = 0; c < 3; c++) target[k][c] = '0;
                hit_cnt[k] = '0;
                x_acc[k] = 0;
                y_acc[k] = 0;
            end
            tol = TOL_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_T0_HUE: target[0][0] = cfg_data;
                    REG_T0_SAT: target[0][1] = cfg_data;
                    REG_T0_VAL: target[0][2] = cfg_data;
                    REG_T1_HUE: target[1][0] = cfg_data;
                    REG_T1_SAT: target[1][1] = cfg_data;
                    REG_T1_VAL: target[1][2] = cfg_data;
                    REG_TOL:    tol = cfg_data;
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                a = {m_found0, m_hits0, m_sumx0, m_sumy0, m_found1, m_hits1, m_sumx1, m_sumy1};
                if (moments_q.size() == 0) begin
                    report("unexpected result", 0, 1);
                end else begin
                    e = moments_q.pop_front();
                    if (e.b0.found != a.b0.found) report("found0", e.b0.found, a.b0.found);
                    if (e.b0.hits != a.b0.hits) report("hits0", e.b0.hits, a.b0.hits);
                    if (e.b0.sumx != a.b0.sumx) report("sumx0", e.b0.sumx, a.b0.sumx);
                    if (e.b0.sumy != a.b0.sumy) report("sumy0", e.b0.sumy, a.b0.sumy);
                    if (e.b1.found != a.b1.found) report("found1", e.b1.found, a.b1.found);
                    if (e.b1.hits != a.b1.hits) report("hits1", e.b1.hits, a.b1.hits);
                    if (e.b1.sumx != a.b1.sumx) report("sumx1", e.b1.sumx, a.b1.sumx);
                    if (e.b1.sumy != a.b1.sumy) report("sumy1", e.b1.sumy, a.b1.sumy);
                end
            end
            if (s_valid && s_ready) begin
                hsv = rgb_to_hsv(s_red, s_green, s_blue);
                for (int k = 0; k < 2; k++) begin
                    hit = slot_on(k);
                    for (c = 0; c < 3; c++) begin
                        lo = int'(target[k][c]) - int'(tol);
                        hi = int'(target[k][c]) + int'(tol);
                        if (int'(hsv[23-8*c -: 8]) < lo || int'(hsv[23-8*c -: 8]) > hi)
                            hit = 0;
                    end
                    if (hit) begin
                        if (hit_cnt[k] != COUNT_MAX) hit_cnt[k]++;
                        // Coordinates cannot exceed the side limit at this width.
                        x_acc[k] += s_pos_x;
                        y_acc[k] += s_pos_y;
                        if (x_acc[k] > longint'(SUM_MAX)) x_acc[k] = longint'(SUM_MAX);
                        if (y_acc[k] > longint'(SUM_MAX)) y_acc[k] = longint'(SUM_MAX);
                    end
                end
                if (s_frame_end) begin
                    moments_q.push_back({close_slot(0), close_slot(1)});
                    for (int k = 0; k < 2; k++) begin
                        hit_cnt[k] = '0;
                        x_acc[k] = 0;
                        y_acc[k] = 0;
                    end
                end
            end
        end
        frames_pending = moments_q.size();
    end

    initial begin
        fail_count = 0;
        frames_pending = 0;
    end
endmodule

// File: tb/sv/hsv_color_blob_moments_test.sv
`timescale 1ns / 100ps

module hsv_color_blob_moments_test;
    import hcbm_pkg::*;

    localparam logic [IDX_W-1:0] REG_SPARE = 3'd7;
    localparam int LIMIT_CYCLES = 800000;
    localparam int PHASE_ITEMS = 275;

    logic aclk, aresetn;
    logic cfg_valid, cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [PIX_W-1:0] cfg_data;
    logic s_valid, s_ready;
    logic [PIX_W-1:0] s_red, s_green, s_blue;
    logic [COORD_W-1:0] s_pos_x, s_pos_y;
    logic s_frame_end;
    logic m_valid, m_ready;
    logic m_found0, m_found1;
    logic [HITS_W-1:0] m_hits0, m_hits1;
    logic [SUM_W-1:0] m_sumx0, m_sumy0, m_sumx1, m_sumy1;
    int fail_count, frames_pending;
    int send_idle_pct, recv_stall_pct, cycle_cnt;
    logic [23:0] seed_rgb[2];

    hsv_color_blob_moments i_dut (.*);

    hsv_color_blob_moments_checker i_chk (.*);

    initial begin
        aclk = 0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        cycle_cnt = 0;
        forever begin
            @(posedge aclk);
            cycle_cnt++;
            if (cycle_cnt >= LIMIT_CYCLES) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [7:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    // Lets the pipeline empty: every frame result out, then the pixel latency.
    task automatic drain;
        s_valid = 0;
        while (frames_pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_pixel(input logic [23:0] rgb, input logic [10:0] x,
                              input logic [10:0] y, input logic fe);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        end
        {s_red, s_green, s_blue} = rgb;
        s_pos_x = x;
        s_pos_y = y;
        s_frame_end = fe;
        s_valid = 1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic set_targets(input logic [23:0] t0, input logic [23:0] t1,
                               input logic [7:0] t);
        write_reg(REG_T0_HUE, t0[23:16]);
        write_reg(REG_T0_SAT, t0[15:8]);
        write_reg(REG_T0_VAL, t0[7:0]);
        write_reg(REG_T1_HUE, t1[23:16]);
        write_reg(REG_T1_SAT, t1[15:8]);
        write_reg(REG_T1_VAL, t1[7:0]);
        write_reg(REG_TOL, t);
        write_reg(REG_SPARE, 8'($urandom));
    endtask

    function automatic logic [23:0] seed_hsv(input logic [23:0] rgb);
        logic [23:0] h;
        h = i_chk.rgb_to_hsv(rgb[23:16], rgb[15:8], rgb[7:0]);
        if (h[23:16] == 0) h[23:16] = 1;
        if (h[15:8] == 0) h[15:8] = 1;
        if (h[7:0] == 0) h[7:0] = 1;
        return h;
    endfunction

    // Mostly near one of the seed colors, so that targets are actually hit.
    function automatic logic [23:0] random_rgb;
        logic [23:0] c;
        int d;
        if ($urandom_range(9) < 3) return 24'($urandom);
        c = seed_rgb[$urandom_range(1)];
        for (int i = 0; i < 3; i++) begin
            d = int'(c[8*i +: 8]) + $urandom_range(8) - 4;
            if (d < 0) d = 0;
            if (d > 255) d = 255;
            c[8*i +: 8] = d[7:0];
        end
        return c;
    endfunction

    initial begin
        logic [23:0] t0, t1;
        logic [7:0] tl;
        aresetn = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        s_valid = 0; s_red = '0; s_green = '0; s_blue = '0;
        s_pos_x = '0; s_pos_y = '0; s_frame_end = 0;
        m_ready = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: green and yellow targets, then corner colors and coordinates.
        seed_rgb[0] = 24'h28C828;
        seed_rgb[1] = 24'hFFFF00;
        set_targets(seed_hsv(seed_rgb[0]), seed_hsv(seed_rgb[1]), TOL_RESET);
        send_pixel(24'h28C828, 11'd0, 11'd0, 0);
        send_pixel(24'hFFFF00, 11'd2047, 11'd2047, 0);
        send_pixel(24'h000000, 11'd5, 11'd7, 0);
        send_pixel(24'hFFFFFF, 11'd2047, 11'd0, 0);
        send_pixel(24'h808080, 11'd0, 11'd2047, 1);
        send_pixel(24'hFF0001, 11'd1, 11'd1, 0);      // hue rounds up to 180, wraps
        send_pixel(24'hFF00FF, 11'd3, 11'd4, 0);
        send_pixel(24'h00FFFF, 11'd3, 11'd4, 0);      // green-blue tie
        send_pixel(24'hFF0000, 11'd9, 11'd9, 0);
        send_pixel(24'h00FF00, 11'd9, 11'd9, 0);
        send_pixel(24'h0000FF, 11'd9, 11'd9, 0);
        send_pixel(24'h2AC828, 11'd1024, 11'd1023, 0);
        send_pixel(24'hF0FF00, 11'd2046, 11'd1, 1);
        send_pixel(24'h010000, 11'd0, 11'd0, 1);      // frame with no hits
        send_pixel(24'h28C828, 11'd2047, 11'd2047, 1);
        drain;

        for (int p = 0; p < 7; p++) begin
            seed_rgb[0] = 24'($urandom);
            seed_rgb[1] = 24'($urandom);
            t0 = seed_hsv(seed_rgb[0]);
            t1 = seed_hsv(seed_rgb[1]);
            tl = 8'($urandom_range(30));
            case (p)
                1: tl = 8'd0;
                2: tl = 8'd255;
                3: begin
                    t0 = {8'd180, 8'd255, 8'd255};
                    seed_rgb[0] = 24'hFF0001;
                    t1[15:8] = 8'd0;
                end
                5: begin
                    t0[23:16] = 8'd0;
                    t1[7:0] = 8'd0;
                end
                default: ;
            endcase
            set_targets(t0, t1, tl);
            send_idle_pct = (p % 4 == 1) ? 79 : (p % 4 == 3) ? 13 : 0;
            recv_stall_pct = (p % 4 == 2) ? 79 : (p % 4 == 3) ? 13 : 0;
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == PHASE_ITEMS / 2) drain;
                send_pixel(random_rgb(), 11'($urandom), 11'($urandom),
                           $urandom_range(11) == 0);
            end
            drain;
        end

        while (frames_pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
